// File: hdl/mofsq_pkg.sv
`timescale 1ns / 1ps

package mofsq_pkg;

    localparam int SAMPLES_PER_READING = 5;
    localparam int SAMPLE_BITS         = 12;
    localparam int COUNT_W             = $clog2(SAMPLES_PER_READING + 1);
    localparam int MEDIAN_IDX          = SAMPLES_PER_READING / 2;
    localparam int ERR_W               = 8;
    localparam int CFG_IDX_W           = 2;
    localparam int CFG_DATA_W          = 12;

    localparam logic [ERR_W-1:0] ERR_COUNT_MAX = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FAULT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_ON_VALUE  = 2'd2;

    localparam logic [ERR_W-1:0]      RST_ERROR_LIMIT     = 8'd10;
    localparam logic [CFG_DATA_W-1:0] RST_LOW_FAULT_LIMIT = 12'h820;
    localparam logic [CFG_DATA_W-1:0] RST_POWER_ON_VALUE  = 12'd1360;

    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_MAPFAIL = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic    gt;
        sample_t value;
    } chain_link_t;

    typedef struct packed {
        logic    insert;
        sample_t value;
    } chain_ctrl_t;

endpackage

// File: hdl/mofsq_cell.sv
`timescale 1ns / 1ps

module mofsq_cell (
    input  logic                  aclk,
    input  mofsq_pkg::chain_ctrl_t ctrl,
    input  logic                  occupied,
    input  mofsq_pkg::chain_link_t left_link,
    output mofsq_pkg::chain_link_t link
);
    import mofsq_pkg::*;

    sample_t value_reg;
    sample_t value_next;
    logic    gt;

    assign gt = !occupied || (value_reg > ctrl.value);

    always_comb begin
        value_next = value_reg;
        if (ctrl.insert && gt) begin
            value_next = left_link.gt ? left_link.value : ctrl.value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign link.gt    = gt;
    assign link.value = value_reg;

endmodule

// File: hdl/mofsq_chain.sv
`timescale 1ns / 1ps

module mofsq_chain (
    input  logic                         aclk,
    input  mofsq_pkg::chain_ctrl_t       ctrl,
    input  logic [mofsq_pkg::COUNT_W-1:0] fill_count,
    output mofsq_pkg::sample_t           median
);
    import mofsq_pkg::*;

    chain_link_t links [SAMPLES_PER_READING];
    chain_link_t lefts [SAMPLES_PER_READING];

    for (genvar i = 0; i < SAMPLES_PER_READING; i++) begin : g_cell
        logic occupied;
        assign occupied = COUNT_W'(i) < fill_count;
        if (i == 0) begin : g_head
            assign lefts[i] = '0;
        end else begin : g_body
            assign lefts[i] = links[i-1];
        end
        mofsq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occupied  (occupied),
            .left_link (lefts[i]),
            .link      (links[i])
        );
    end

    assign median = links[MEDIAN_IDX].value;

endmodule

// File: hdl/median_of_five_sensor_qualifier_core.sv
`timescale 1ns / 1ps

// Median-of-five temperature qualifier. Samples enter a row of five sorting cells, one
// beat per cycle while s_ready is high, each insertion placing the sample in order
// across all cells in the same cycle. A beat that completes a set of five, or a mapping
// failure event, moves to a result stage that qualifies the middle cell against the
// limits (a mapping failure instead reports a failed round), updates the fault-round
// count and loads the output register; while the result stage is occupied s_ready is
// low. A finished result may wait in the output register while further samples are
// accepted; the next set-completing beat waits in the result stage until the output
// register is free. Results are reported through m_valid/m_ready.
module median_of_five_sensor_qualifier_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mofsq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mofsq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic signed [mofsq_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                              s_last_sensor,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [mofsq_pkg::SAMPLE_BITS-1:0] m_median,
    output logic                              m_sample_fault,
    output logic                              m_round_done,
    output logic                              m_round_ok,
    output logic [mofsq_pkg::ERR_W-1:0]       m_error_count,
    output logic                              m_service_error
);
    import mofsq_pkg::*;

    logic [ERR_W-1:0]   error_limit_reg;
    sample_t            low_fault_limit_reg;
    sample_t            power_on_value_reg;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               round_fault_reg, round_fault_next;
    logic [ERR_W-1:0]   fault_rounds_reg, fault_rounds_next;
    logic               pend_reg, pend_next;
    logic               pend_map_reg, pend_map_next;
    logic               pend_last_reg, pend_last_next;

    logic               m_valid_reg, m_valid_next;
    sample_t            median_reg, median_next;
    logic               fault_reg, fault_next;
    logic               done_reg, done_next;
    logic               ok_reg, ok_next;
    logic [ERR_W-1:0]   count_out_reg;
    logic               service_reg, service_next;

    chain_ctrl_t        ctrl;
    sample_t            chain_median;
    logic               s_beat;
    logic               fire;
    logic               med_fault;
    logic               rf_new;
    logic [ERR_W-1:0]   fr_bump;

    assign s_ready = !pend_reg;
    assign s_beat  = s_valid && s_ready;
    assign fire    = pend_reg && (!m_valid_reg || m_ready);

    assign ctrl.insert = s_beat && (s_command == CMD_SAMPLE);
    assign ctrl.value  = s_sample;

    mofsq_chain u_chain (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .fill_count (count_reg),
        .median     (chain_median)
    );

    assign med_fault = (chain_median < low_fault_limit_reg) ||
                       (chain_median == power_on_value_reg);
    assign rf_new    = round_fault_reg || med_fault;
    assign fr_bump   = (fault_rounds_reg == ERR_COUNT_MAX) ? fault_rounds_reg
                                                           : fault_rounds_reg + 1'b1;

    always_comb begin
        count_next        = count_reg;
        round_fault_next  = round_fault_reg;
        fault_rounds_next = fault_rounds_reg;
        pend_next         = pend_reg;
        pend_map_next     = pend_map_reg;
        pend_last_next    = pend_last_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        median_next       = median_reg;
        fault_next        = fault_reg;
        done_next         = done_reg;
        ok_next           = ok_reg;
        service_next      = service_reg;

        if (s_beat) begin
            if (s_command == CMD_MAPFAIL) begin
                count_next    = '0;
                pend_next     = 1'b1;
                pend_map_next = 1'b1;
            end else if (count_reg == COUNT_W'(SAMPLES_PER_READING - 1)) begin
                count_next     = '0;
                pend_next      = 1'b1;
                pend_map_next  = 1'b0;
                pend_last_next = s_last_sensor;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end

        if (fire) begin
            pend_next    = 1'b0;
            m_valid_next = 1'b1;
            if (pend_map_reg) begin
                fault_rounds_next = fr_bump;
                round_fault_next  = 1'b0;
                median_next       = '0;
                fault_next        = 1'b0;
                done_next         = 1'b1;
                ok_next           = 1'b0;
            end else begin
                median_next = chain_median;
                fault_next  = med_fault;
                done_next   = pend_last_reg;
                ok_next     = pend_last_reg && !rf_new;
                if (pend_last_reg) begin
                    fault_rounds_next = rf_new ? fr_bump : '0;
                    round_fault_next  = 1'b0;
                end else begin
                    round_fault_next  = rf_new;
                end
            end
            service_next = fault_rounds_next > error_limit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_limit_reg     <= RST_ERROR_LIMIT;
            low_fault_limit_reg <= RST_LOW_FAULT_LIMIT;
            power_on_value_reg  <= RST_POWER_ON_VALUE;
            count_reg           <= '0;
            round_fault_reg     <= 1'b0;
            fault_rounds_reg    <= '0;
            pend_reg            <= 1'b0;
            pend_map_reg        <= 1'b0;
            pend_last_reg       <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ERROR_LIMIT:     error_limit_reg     <= cfg_wdata[ERR_W-1:0];
                    REG_LOW_FAULT_LIMIT: low_fault_limit_reg <= cfg_wdata;
                    REG_POWER_ON_VALUE:  power_on_value_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            count_reg        <= count_next;
            round_fault_reg  <= round_fault_next;
            fault_rounds_reg <= fault_rounds_next;
            pend_reg         <= pend_next;
            pend_map_reg     <= pend_map_next;
            pend_last_reg    <= pend_last_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        median_reg    <= median_next;
        fault_reg     <= fault_next;
        done_reg      <= done_next;
        ok_reg        <= ok_next;
        count_out_reg <= fault_rounds_next;
        service_reg   <= service_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_median        = median_reg;
    assign m_sample_fault  = fault_reg;
    assign m_round_done    = done_reg;
    assign m_round_ok      = ok_reg;
    assign m_error_count   = count_out_reg;
    assign m_service_error = service_reg;

    a_fire_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg && !pend_reg)
        else $error("result stage did not load output register");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(SAMPLES_PER_READING - 1))
        else $error("fill count out of range");

    a_ok_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && ok_reg |-> done_reg && (count_out_reg == '0) && !service_reg)
        else $error("clean round result with nonzero error count");

    a_mapfail_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && pend_map_reg |=> done_reg && !ok_reg && !fault_reg)
        else $error("mapping failure result fields wrong");

endmodule
